// ===== rtl/core/prrts_pkg.sv =====
package prrts_pkg;

    // Table size and lowest priority level (idle task level)
    localparam int MAX_TASKS  = 8;
    localparam int IDLE_LEVEL = 4;

    // Input word kinds
    typedef enum logic [2:0] {
        KIND_ADD    = 3'd0,
        KIND_TICK   = 3'd1,
        KIND_DELAY  = 3'd2,
        KIND_FORCE  = 3'd3,
        KIND_QUERY  = 3'd4
    } t_kind;

    // Task status codes
    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_ISR   = 2'd2;

    // Configuration register byte addresses
    localparam logic [1:0] REG_BLOCKED_HOLD = 2'd0;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_LEVEL,
        S_PICK,
        S_QUERY,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/prrts_match.sv =====
// Shared slot matcher: compares one table entry against a level and a status
module prrts_match (
    input  logic [2:0] i_prio,
    input  logic [1:0] i_stat,
    input  logic [2:0] i_level,
    input  logic [1:0] i_want,
    output logic       o_hit
);
    assign o_hit = (i_prio == i_level) && (i_stat == i_want);
endmodule

// ===== rtl/core/priority_round_robin_task_scheduler_core.sv =====
// Channel | Dir | Signals                 | Word
// s_axis  | in  | tvalid tready tdata     | kind, task_index, priority_req, delay_ticks,
//         |     |                         | wanted_state, from_isr
// m_axis  | out | tvalid tready tdata     | current_task, switched, match_count, error_code
// apb     | in  | psel penable pwrite ... | blocked_hold_ticks at 0x0
// With n = task_count+1 scan positions: add, force, unknown kinds and a delay that blocks
// nothing go straight from acceptance to the done state; a query scans all n positions.
// A tick scans all n for delays, then each level in turn until one has a ready task (all
// IDLE_LEVEL+1 levels if none ready), picks and finishes; a blocking delay adds an apply step.
// Reset is synchronous, active low. The block takes a word only when idle and the
// output register is empty; a stalled result holds in that register.
module priority_round_robin_task_scheduler_core #(
    parameter int DELAY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] kind, [6:3] task_index, [9:7] priority_req, [41:10] delay_ticks,
    // [43:42] wanted_state, [44] from_isr, zero fill to 48
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] current_task, [4] switched, [8:5] match_count, [10:9] error_code
    output logic [15:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int SLOTS = prrts_pkg::MAX_TASKS + 1;
    localparam int SW    = $clog2(SLOTS + 1);
    localparam int IW    = $clog2(SLOTS);
    localparam logic [SW-1:0] IDLE_SLOT = SW'(prrts_pkg::MAX_TASKS);
    localparam logic [2:0] IDLE_LV = 3'(prrts_pkg::IDLE_LEVEL);

    logic [2:0]            r_prio  [SLOTS];
    logic [1:0]            r_stat  [SLOTS];
    logic [DELAY_BITS-1:0] r_dly   [SLOTS];
    logic [SW-1:0]         r_count, r_run, r_ptr, r_pos, r_nmatch;
    logic [2:0]            r_last, r_level;
    logic [31:0]           r_hold;
    logic [47:0]           r_in;
    logic                  r_sw;
    logic [1:0]            r_err;
    logic                  r_oval;
    prrts_pkg::t_state     r_state, n_state;

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr == prrts_pkg::REG_BLOCKED_HOLD) ? r_hold : 32'd0;

    // Input fields
    logic [2:0]            w_kind, w_qprio;
    logic [3:0]            w_tidx;
    logic [DELAY_BITS-1:0] w_dly;
    logic [1:0]            w_want;
    logic                  w_isr;
    assign w_kind  = r_in[2:0];
    assign w_tidx  = r_in[6:3];
    assign w_qprio = r_in[9:7];
    assign w_dly   = r_in[10 +: DELAY_BITS];
    assign w_want  = r_in[43:42];
    assign w_isr   = r_in[44];

    // Slot at the current scan position
    logic [SW-1:0] w_slot;
    logic [SW-1:0] w_npos;
    assign w_slot = (r_pos < r_count) ? r_pos : IDLE_SLOT;
    assign w_npos = (r_pos + 1'b1 >= r_count + 1'b1) ? '0 : r_pos + 1'b1;

    logic [IW-1:0] w_si, w_ri, w_ci, w_ti;
    assign w_si = w_slot[IW-1:0];
    assign w_ri = r_run[IW-1:0];
    assign w_ci = r_count[IW-1:0];
    assign w_ti = w_tidx[IW-1:0];

    // Shared matcher
    logic [2:0] w_mlevel;
    logic [1:0] w_mwant;
    logic       w_hit;
    assign w_mlevel = (r_state == prrts_pkg::S_QUERY) ? w_qprio : r_level;
    assign w_mwant  = (r_state == prrts_pkg::S_QUERY) ? w_want : prrts_pkg::ST_READY;
    prrts_match u_match (
        .i_prio (r_prio[w_si]),
        .i_stat (r_stat[w_si]),
        .i_level(w_mlevel),
        .i_want (w_mwant),
        .o_hit  (w_hit)
    );

    logic w_present;
    assign w_present = (SW'(w_tidx) == IDLE_SLOT || SW'(w_tidx) < r_count) &&
                       ({1'b0, w_tidx} < 5'(SLOTS));

    // Delay word that blocks the running task and needs a scheduling pass
    logic w_resched;
    assign w_resched = !r_sw && (w_kind == prrts_pkg::KIND_DELAY) && !w_isr &&
                       (w_dly != '0);

    assign s_axis_tready = (r_state == prrts_pkg::S_IDLE) && !m_axis_tvalid;
    assign m_axis_tdata  = {5'd0, r_err, 4'(r_nmatch), r_sw, 4'(r_run)};
    assign m_axis_tvalid = r_oval;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prrts_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prrts_pkg::S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    if (s_axis_tdata[2:0] == prrts_pkg::KIND_TICK)
                        n_state = prrts_pkg::S_TICK;
                    else if (s_axis_tdata[2:0] == prrts_pkg::KIND_QUERY)
                        n_state = prrts_pkg::S_QUERY;
                    else
                        n_state = prrts_pkg::S_DONE;
                end
            end
            prrts_pkg::S_TICK: begin
                if (r_pos == r_count) n_state = prrts_pkg::S_LEVEL;
            end
            prrts_pkg::S_LEVEL: begin
                if (w_hit)
                    n_state = prrts_pkg::S_PICK;
                else if (r_pos == r_count && r_level == IDLE_LV)
                    n_state = prrts_pkg::S_DONE;
            end
            prrts_pkg::S_PICK: begin
                if (w_hit) n_state = prrts_pkg::S_DONE;
            end
            prrts_pkg::S_QUERY: begin
                if (r_pos == r_count) n_state = prrts_pkg::S_IDLE;
            end
            prrts_pkg::S_DONE: begin
                n_state = w_resched ? prrts_pkg::S_LEVEL : prrts_pkg::S_IDLE;
            end
            default: n_state = prrts_pkg::S_IDLE;
        endcase
    end

    // Task table and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval   <= 1'b0;
            r_count  <= '0;
            r_run    <= IDLE_SLOT;
            r_ptr    <= '0;
            r_last   <= '0;
            r_hold   <= 32'd1;
            r_in     <= '0;
            r_sw     <= 1'b0;
            r_err    <= prrts_pkg::ERR_NONE;
            r_nmatch <= '0;
            r_pos    <= '0;
            r_level  <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_prio[i] <= (i == prrts_pkg::MAX_TASKS) ? IDLE_LV : 3'd0;
                r_stat[i] <= prrts_pkg::ST_READY;
                r_dly[i]  <= '0;
            end
        end else begin
            if (psel && penable && pwrite && paddr == prrts_pkg::REG_BLOCKED_HOLD)
                r_hold <= pwdata;
            // result register
            if ((r_state == prrts_pkg::S_DONE && !w_resched) ||
                (r_state == prrts_pkg::S_QUERY && r_pos == r_count))
                r_oval <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                r_oval <= 1'b0;
            unique case (r_state)
                prrts_pkg::S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_in     <= s_axis_tdata;
                        r_sw     <= 1'b0;
                        r_err    <= prrts_pkg::ERR_NONE;
                        r_nmatch <= '0;
                        r_pos    <= '0;
                    end
                end
                prrts_pkg::S_TICK: begin
                    if (r_dly[w_si] != '0) begin
                        r_dly[w_si]  <= r_dly[w_si] - 1'b1;
                        r_stat[w_si] <= prrts_pkg::ST_BLOCKED;
                    end else begin
                        r_stat[w_si] <= prrts_pkg::ST_READY;
                    end
                    if (r_pos == r_count) begin
                        r_level <= '0;
                        r_pos   <= '0;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                prrts_pkg::S_LEVEL: begin
                    // look for any ready task at r_level
                    if (w_hit) begin
                        r_pos <= (r_level != r_last || r_ptr >= r_count + 1'b1) ?
                                 '0 : r_ptr;
                    end else if (r_pos == r_count) begin
                        r_pos <= '0;
                        if (r_level == IDLE_LV) begin
                            r_sw <= 1'b1;
                        end else begin
                            r_level <= r_level + 1'b1;
                        end
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                prrts_pkg::S_PICK: begin
                    if (w_hit) begin
                        r_run        <= w_slot;
                        r_stat[w_si] <= prrts_pkg::ST_RUNNING;
                        r_ptr        <= r_pos + 1'b1;
                        r_last       <= r_level;
                        r_sw         <= 1'b1;
                    end else begin
                        r_pos <= w_npos;
                    end
                end
                prrts_pkg::S_QUERY: begin
                    if (w_hit) r_nmatch <= r_nmatch + 1'b1;
                    r_pos <= r_pos + 1'b1;
                end
                prrts_pkg::S_DONE: begin
                    if (!r_sw) begin
                        unique case (w_kind)
                            prrts_pkg::KIND_ADD: begin
                                if (r_count < SW'(prrts_pkg::MAX_TASKS)) begin
                                    r_prio[w_ci] <= (w_qprio > IDLE_LV) ? IDLE_LV : w_qprio;
                                    r_stat[w_ci] <= prrts_pkg::ST_READY;
                                    r_dly[w_ci]  <= '0;
                                    r_count      <= r_count + 1'b1;
                                end else begin
                                    r_err <= prrts_pkg::ERR_FULL;
                                end
                            end
                            prrts_pkg::KIND_DELAY: begin
                                if (w_isr) begin
                                    r_err <= prrts_pkg::ERR_ISR;
                                end else if (w_dly != '0) begin
                                    r_dly[w_ri]  <= w_dly;
                                    r_stat[w_ri] <= prrts_pkg::ST_BLOCKED;
                                    r_level      <= '0;
                                    r_pos        <= '0;
                                end
                            end
                            prrts_pkg::KIND_FORCE: begin
                                if (w_present) begin
                                    if (w_want == prrts_pkg::ST_BLOCKED) begin
                                        r_dly[w_ti]  <= r_hold[DELAY_BITS-1:0];
                                        r_stat[w_ti] <= prrts_pkg::ST_BLOCKED;
                                    end else if (w_want == prrts_pkg::ST_READY) begin
                                        r_dly[w_ti]  <= '0;
                                        r_stat[w_ti] <= prrts_pkg::ST_READY;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== bench/priority_round_robin_task_scheduler_core_test.sv =====
`timescale 1ns / 1ps

module priority_round_robin_task_scheduler_core_test;

    localparam int NTASK  = 8;
    localparam int IDLE_S = NTASK;
    localparam int TOPLVL = 4;
    localparam int LIMIT  = 1200000;

    // Expected result word fields
    typedef struct packed {
        logic [3:0] cur;
        logic       sw;
        logic [3:0] cnt;
        logic [1:0] err;
    } t_outcome;

    // Scoreboard: task table predictor plus queue of pending outcomes
    class sched_board;
        logic [2:0]  prio_tab [0:NTASK];
        logic [1:0]  stat_tab [0:NTASK];
        logic [31:0] dly_tab  [0:NTASK];
        int          n_tasks;
        int          run_slot;
        int          rr_ptr;
        int          prev_lvl;
        logic [31:0] hold_ticks;
        t_outcome    pending [$];
        int          n_err;
        int          n_ok;

        function void init();
            for (int i = 0; i <= NTASK; i++) begin
                prio_tab[i] = '0;
                stat_tab[i] = prrts_pkg::ST_READY;
                dly_tab[i]  = '0;
            end
            prio_tab[IDLE_S] = 3'(TOPLVL);
            n_tasks = 0;
            run_slot = IDLE_S;
            rr_ptr = 0;
            prev_lvl = 0;
            hold_ticks = 32'd1;
            n_err = 0;
            n_ok = 0;
        endfunction

        function int slot_at(int p);
            return (p < n_tasks) ? p : IDLE_S;
        endfunction

        function int tally(int lvl, logic [1:0] st);
            int n;
            n = 0;
            for (int p = 0; p <= n_tasks; p++)
                if (prio_tab[slot_at(p)] == lvl && stat_tab[slot_at(p)] == st) n++;
            return n;
        endfunction

        // Highest ready level, rotating pick inside it
        function void pick_next();
            int p;
            int npos;
            int s;
            npos = n_tasks + 1;
            for (int lvl = 0; lvl <= TOPLVL; lvl++) begin
                if (tally(lvl, prrts_pkg::ST_READY) == 0) continue;
                p = rr_ptr;
                if (lvl != prev_lvl || p >= npos) p = 0;
                for (int t = 0; t < npos; t++) begin
                    s = slot_at(p);
                    p++;
                    if (prio_tab[s] == lvl && stat_tab[s] == prrts_pkg::ST_READY) begin
                        run_slot = s;
                        stat_tab[s] = prrts_pkg::ST_RUNNING;
                        break;
                    end
                    if (p >= npos) p = 0;
                end
                rr_ptr = p;
                prev_lvl = lvl;
                return;
            end
        endfunction

        function void note_word(logic [47:0] w);
            logic [2:0]  k;
            logic [3:0]  ti;
            logic [2:0]  pr;
            logic [31:0] dl;
            logic [1:0]  ws;
            logic        isr;
            t_outcome    o;
            k = w[2:0]; ti = w[6:3]; pr = w[9:7]; dl = w[41:10]; ws = w[43:42];
            isr = w[44];
            o = '0;
            case (k)
                prrts_pkg::KIND_ADD: begin
                    if (n_tasks < NTASK) begin
                        prio_tab[n_tasks] = (pr > TOPLVL) ? 3'(TOPLVL) : pr;
                        stat_tab[n_tasks] = prrts_pkg::ST_READY;
                        dly_tab[n_tasks] = '0;
                        n_tasks++;
                    end else begin
                        o.err = prrts_pkg::ERR_FULL;
                    end
                end
                prrts_pkg::KIND_TICK: begin
                    for (int p = 0; p <= n_tasks; p++) begin
                        if (dly_tab[slot_at(p)] != 0) begin
                            dly_tab[slot_at(p)]--;
                            stat_tab[slot_at(p)] = prrts_pkg::ST_BLOCKED;
                        end else begin
                            stat_tab[slot_at(p)] = prrts_pkg::ST_READY;
                        end
                    end
                    pick_next();
                    o.sw = 1'b1;
                end
                prrts_pkg::KIND_DELAY: begin
                    if (isr) begin
                        o.err = prrts_pkg::ERR_ISR;
                    end else if (dl != 0) begin
                        dly_tab[run_slot] = dl;
                        stat_tab[run_slot] = prrts_pkg::ST_BLOCKED;
                        pick_next();
                        o.sw = 1'b1;
                    end
                end
                prrts_pkg::KIND_FORCE: begin
                    if (ti == IDLE_S || ti < n_tasks) begin
                        if (ws == prrts_pkg::ST_BLOCKED) begin
                            dly_tab[ti] = hold_ticks;
                            stat_tab[ti] = prrts_pkg::ST_BLOCKED;
                        end else if (ws == prrts_pkg::ST_READY) begin
                            dly_tab[ti] = '0;
                            stat_tab[ti] = prrts_pkg::ST_READY;
                        end
                    end
                end
                prrts_pkg::KIND_QUERY: o.cnt = 4'(tally(pr, ws));
                default: ;
            endcase
            o.cur = 4'(run_slot);
            pending.push_back(o);
        endfunction

        task check_word(logic [15:0] w);
            t_outcome e;
            if (pending.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            e = pending.pop_front();
            n_ok++;
            if (w[3:0] != e.cur) report($sformatf("current_task %0d exp %0d", w[3:0], e.cur));
            if (w[4] != e.sw) report($sformatf("switched %0b exp %0b", w[4], e.sw));
            if (w[8:5] != e.cnt) report($sformatf("match_count %0d exp %0d", w[8:5], e.cnt));
            if (w[10:9] != e.err) report($sformatf("error_code %0d exp %0d", w[10:9], e.err));
        endtask

        task report(string msg);
            n_err++;
            $display("MISMATCH @%0t (word %0d): %s", $time, n_ok, msg);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        psel, penable, pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sched_board board;
    int          cycles;
    int          sent;
    bit          hold_off;
    bit          stall_done;

    priority_round_robin_task_scheduler_core uut (.*);

    // Clock
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** priority_round_robin_task_scheduler_core: FAILED **");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);

    // Receiver: random stalls, one long hold-off
    initial begin
        int w;
        m_axis_tready = 0;
        stall_done = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off && !stall_done) begin
                m_axis_tready <= 0;
                repeat (400) @(posedge i_clk);
                stall_done = 1;
            end
            w = (sent % 300 < 60) ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                m_axis_tready <= 0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
        end
    end

    function automatic logic [47:0] pack_word(int k, int ti, int pr, int dl, int ws, int isr);
        return {3'b0, 1'(isr), 2'(ws), 32'(dl), 3'(pr), 4'(ti), 3'(k)};
    endfunction

    // Send one word, with an optional random gap before it
    task automatic send_word(logic [47:0] w, bit gaps);
        int g;
        g = gaps ? $urandom_range(0, 5) : 0;
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_word(w);
        sent++;
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= prrts_pkg::REG_BLOCKED_HOLD;
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.hold_ticks = v;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_delay();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return $urandom;
            default: return $urandom_range(1, 4);
        endcase
    endfunction

    // Mostly well-formed kernel traffic, some noise
    function automatic logic [47:0] rand_word();
        logic [2:0] k;
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) k = prrts_pkg::KIND_ADD;
        else if (r < 40) k = prrts_pkg::KIND_TICK;
        else if (r < 58) k = prrts_pkg::KIND_DELAY;
        else if (r < 75) k = prrts_pkg::KIND_FORCE;
        else if (r < 95) k = prrts_pkg::KIND_QUERY;
        else k = 3'($urandom_range(5, 7));
        return pack_word(k,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) :
                                                       $urandom_range(0, 8),
                         ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) :
                                                       $urandom_range(0, 4),
                         rand_delay(), $urandom_range(0, 3), ($urandom_range(0, 5) == 0));
    endfunction

    initial begin
        logic [31:0] holds [4];
        board = new();
        board.init();
        cycles = 0; sent = 0; hold_off = 0;
        holds = '{32'd1, 32'hFFFF_FFFF, 32'd3, 32'd2};
        i_rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: idle-only tick, query, delays, adds incl. saturation and full table, forces, bad kind
        send_word(pack_word(prrts_pkg::KIND_TICK, 0, 0, 0, 0, 1), 0);
        send_word(pack_word(prrts_pkg::KIND_QUERY, 0, 4, 0, prrts_pkg::ST_RUNNING, 0), 0);
        send_word(pack_word(prrts_pkg::KIND_DELAY, 0, 0, 5, 0, 1), 0);
        send_word(pack_word(prrts_pkg::KIND_DELAY, 0, 0, 0, 0, 0), 0);
        send_word(pack_word(prrts_pkg::KIND_ADD, 0, 7, 0, 0, 0), 0);
        for (int i = 0; i < 7; i++)
            send_word(pack_word(prrts_pkg::KIND_ADD, 0, i % 3, 0, 0, 1), 0);
        send_word(pack_word(prrts_pkg::KIND_ADD, 0, 1, 0, 0, 0), 0);
        send_word(pack_word(prrts_pkg::KIND_TICK, 0, 0, 0, 0, 0), 0);
        send_word(pack_word(prrts_pkg::KIND_DELAY, 0, 0, 32'hFFFF_FFFF, 0, 0), 0);
        send_word(pack_word(prrts_pkg::KIND_FORCE, 1, 0, 0, prrts_pkg::ST_BLOCKED, 0), 0);
        send_word(pack_word(prrts_pkg::KIND_FORCE, 8, 0, 0, prrts_pkg::ST_RUNNING, 0), 0);
        send_word(pack_word(prrts_pkg::KIND_FORCE, 15, 0, 0, prrts_pkg::ST_READY, 0), 0);
        send_word(pack_word(prrts_pkg::KIND_FORCE, 2, 0, 0, 3, 0), 0);
        send_word(pack_word(prrts_pkg::KIND_QUERY, 0, 7, 0, 3, 0), 0);
        send_word(pack_word(prrts_pkg::KIND_TICK, 0, 0, 0, 0, 0), 0);
        send_word(pack_word(7, 0, 0, 0, 0, 0), 0);
        go_idle();

        // Random phases with register changes in between
        for (int ph = 0; ph < 4; ph++) begin
            apb_write(holds[ph]);
            if (ph == 2) begin
                // long receiver hold-off during this phase
                hold_off = 1;
            end
            for (int n = 0; n < 370; n++) send_word(rand_word(), !(ph == 2 && n < 100));
            go_idle();
        end

        $display("%0d words sent over 4 hold-tick settings (1, max, 3, 2); %0d results checked",
                 sent, board.n_ok);
        $display("covered adds to full table, ticks, delays incl. ISR, forces, queries, stall");
        if (board.n_err == 0 && board.pending.size() == 0)
            $display("** priority_round_robin_task_scheduler_core: PASSED **");
        else begin
            $display("%0d mismatches, %0d words outstanding", board.n_err,
                     board.pending.size());
            $display("** priority_round_robin_task_scheduler_core: FAILED **");
        end
        $finish;
    end

endmodule
